// ===== hw/rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants for the block frame deframer.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam logic [7:0]  StartMarkerRst = 8'hC6;
  localparam logic [7:0]  EndMarkerRst   = 8'h6C;
  localparam logic [7:0]  CommandCodeRst = 8'h87;
  localparam logic [7:0]  DataCodeRst    = 8'hE1;
  localparam logic [15:0] MaxLengthRst   = 16'd2048;

  typedef enum logic [2:0] {
    REG_START_MARKER = 3'd0,
    REG_END_MARKER   = 3'd1,
    REG_COMMAND_CODE = 3'd2,
    REG_DATA_CODE    = 3'd3,
    REG_MAX_LENGTH   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_START   = 3'd1,
    ERR_TYPE    = 3'd2,
    ERR_LONG    = 3'd3,
    ERR_TRAILER = 3'd4,
    ERR_LINK    = 3'd5
  } error_code_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  command_code;
    logic [7:0]  data_code;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   payload_byte;
    logic         is_command;
    logic [15:0]  frame_length;
    error_code_t  error_code;
    logic         last;
  } result_t;

endpackage

// ===== hw/rtl/bfd_channel_if.sv =====
// ----------------------------------------------------------------------------
// bfd channel interfaces
// Valid/ready channels for received link bytes and parser results.
// ----------------------------------------------------------------------------
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_error;

  modport source (output valid, output rx_byte, output link_error, input ready);
  modport sink   (input valid, input rx_byte, input link_error, output ready);
endinterface

interface bfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        is_command;
  logic [15:0] frame_length;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output result_kind, output payload_byte,
                  output is_command, output frame_length, output error_code,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input is_command, input frame_length, input error_code,
                  input last, output ready);
endinterface

// ===== hw/rtl/block_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// block_frame_deframer_top
// Parses start/type/length/payload/end blocks from a received byte stream.
//
// in_ch carries one link byte per transaction plus a link_error flag. out_ch
// carries results: a payload byte (kind 0), block complete (kind 1) or block
// error (kind 2, with an error code). Good header bytes give no result.
// Markers, type codes and the length limit sit in an APB register file
// (byte addresses 0x0..0x10); write them only while idle.
//
// Throughput is one byte per cycle unless the receiver stalls with the
// result register full. A byte is held in the input register, then parsed
// and its result written to the result register, which drives out_ch.
// When the receiver stalls, the result register holds and the input register
// fills; in_ch.ready drops only when both are full, and then rises again in
// the cycle the receiver takes the waiting result.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to waiting for a start byte and loads the register defaults.
// ----------------------------------------------------------------------------
module block_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  bfd_in_if.sink                        in_ch,
  bfd_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [bfd_pkg::CfgDataW-1:0]  pwdata,
  output logic [bfd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  bfd_pkg::cfg_t    cfg;
  bfd_pkg::result_t res;
  bfd_pkg::result_t out_res;
  logic             res_valid;
  logic             res_ready;

  bfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bfd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_rx_byte    (in_ch.rx_byte),
    .in_link_error (in_ch.link_error),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  bfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.result_kind  = out_res.kind;
  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.is_command   = out_res.is_command;
  assign out_ch.frame_length = out_res.frame_length;
  assign out_ch.error_code   = out_res.error_code;
  assign out_ch.last         = out_res.last;

endmodule

// ===== hw/rtl/bfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bfd_cfg_regs
// APB register file holding markers, type codes and the length limit.
// ----------------------------------------------------------------------------
module bfd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [bfd_pkg::CfgDataW-1:0]  pwdata,
  output logic [bfd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output bfd_pkg::cfg_t                 cfg
);

  bfd_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= bfd_pkg::StartMarkerRst;
      cfg_r.end_marker   <= bfd_pkg::EndMarkerRst;
      cfg_r.command_code <= bfd_pkg::CommandCodeRst;
      cfg_r.data_code    <= bfd_pkg::DataCodeRst;
      cfg_r.max_length   <= bfd_pkg::MaxLengthRst;
    end else if (wr_en) begin
      case (reg_sel)
        bfd_pkg::REG_START_MARKER: cfg_r.start_marker <= pwdata[7:0];
        bfd_pkg::REG_END_MARKER:   cfg_r.end_marker   <= pwdata[7:0];
        bfd_pkg::REG_COMMAND_CODE: cfg_r.command_code <= pwdata[7:0];
        bfd_pkg::REG_DATA_CODE:    cfg_r.data_code    <= pwdata[7:0];
        bfd_pkg::REG_MAX_LENGTH:   cfg_r.max_length   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bfd_pkg::REG_START_MARKER: prdata = {24'd0, cfg_r.start_marker};
      bfd_pkg::REG_END_MARKER:   prdata = {24'd0, cfg_r.end_marker};
      bfd_pkg::REG_COMMAND_CODE: prdata = {24'd0, cfg_r.command_code};
      bfd_pkg::REG_DATA_CODE:    prdata = {24'd0, cfg_r.data_code};
      bfd_pkg::REG_MAX_LENGTH:   prdata = {16'd0, cfg_r.max_length};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bfd_parser.sv =====
// ----------------------------------------------------------------------------
// bfd_parser
// Input register and block parser; one byte per cycle unless results stall.
// ----------------------------------------------------------------------------
module bfd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  bfd_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_link_error,
  output logic             res_valid,
  input  logic             res_ready,
  output bfd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TYPE = 3'd1,
    PH_LENH = 3'd2,
    PH_LENL = 3'd3,
    PH_DATA = 3'd4,
    PH_TAIL = 3'd5
  } phase_t;

  logic        in_vld_r;
  logic [7:0]  rx_byte_r;
  logic        link_err_r;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic        is_cmd_r, is_cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic        emit;
  bfd_pkg::result_t res_nxt;

  assign advance  = in_vld_r && res_ready;
  assign in_ready = !in_vld_r || advance;
  assign len_full = {len_r[15:8], rx_byte_r};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    is_cmd_nxt = is_cmd_r;
    len_nxt = len_r;
    left_nxt = left_r;
    emit = 1'b0;
    res_nxt = '0;
    res_nxt.kind = bfd_pkg::KIND_ERR;
    res_nxt.error_code = bfd_pkg::ERR_NONE;
    res_nxt.is_command = is_cmd_r;
    res_nxt.frame_length = len_r;
    res_nxt.last = 1'b1;

    if (link_err_r) begin
      emit = 1'b1;
      res_nxt.error_code = bfd_pkg::ERR_LINK;
      phase_nxt = PH_IDLE;
      is_cmd_nxt = 1'b0;
      len_nxt = '0;
      left_nxt = '0;
    end else begin
      case (phase_r)
        PH_TYPE: begin
          if (rx_byte_r == cfg.command_code) begin
            is_cmd_nxt = 1'b1;
            phase_nxt = PH_LENH;
          end else if (rx_byte_r == cfg.data_code) begin
            is_cmd_nxt = 1'b0;
            phase_nxt = PH_LENH;
          end else begin
            emit = 1'b1;
            res_nxt.error_code = bfd_pkg::ERR_TYPE;
            res_nxt.is_command = 1'b0;
            phase_nxt = PH_IDLE;
            is_cmd_nxt = 1'b0;
            len_nxt = '0;
            left_nxt = '0;
          end
        end
        PH_LENH: begin
          len_nxt = {rx_byte_r, 8'd0};
          phase_nxt = PH_LENL;
        end
        PH_LENL: begin
          if (len_full > cfg.max_length) begin
            emit = 1'b1;
            res_nxt.error_code = bfd_pkg::ERR_LONG;
            res_nxt.frame_length = len_full;
            phase_nxt = PH_IDLE;
            is_cmd_nxt = 1'b0;
            len_nxt = '0;
            left_nxt = '0;
          end else begin
            len_nxt = len_full;
            left_nxt = len_full;
            phase_nxt = (len_full == 16'd0) ? PH_TAIL : PH_DATA;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          res_nxt.kind = bfd_pkg::KIND_BYTE;
          res_nxt.payload_byte = rx_byte_r;
          res_nxt.last = 1'b0;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_TAIL;
          end
        end
        PH_TAIL: begin
          emit = 1'b1;
          if (rx_byte_r == cfg.end_marker) begin
            res_nxt.kind = bfd_pkg::KIND_DONE;
          end else begin
            res_nxt.error_code = bfd_pkg::ERR_TRAILER;
          end
          phase_nxt = PH_IDLE;
          is_cmd_nxt = 1'b0;
          len_nxt = '0;
          left_nxt = '0;
        end
        default: begin
          is_cmd_nxt = 1'b0;
          len_nxt = '0;
          left_nxt = '0;
          if (rx_byte_r != cfg.start_marker) begin
            emit = 1'b1;
            res_nxt.error_code = bfd_pkg::ERR_START;
            res_nxt.is_command = 1'b0;
            res_nxt.frame_length = '0;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  assign res_valid = advance && emit;
  assign res       = res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_IDLE;
      is_cmd_r <= 1'b0;
      len_r    <= '0;
      left_r   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        phase_r  <= phase_nxt;
        is_cmd_r <= is_cmd_nxt;
        len_r    <= len_nxt;
        left_r   <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rx_byte_r  <= in_rx_byte;
      link_err_r <= in_link_error;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> phase_r == PH_IDLE)
    else $error("parser not idle after reset");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (left_r != 16'd0) && (left_r <= len_r))
    else $error("payload count out of range");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_TYPE) |-> (len_r == 16'd0) && (left_r == 16'd0))
    else $error("block state not cleared between blocks");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(rx_byte_r) && $stable(link_err_r))
    else $error("stalled input register changed");

endmodule

// ===== hw/rtl/bfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// bfd_out_stage
// Result register that decouples the parser from the result receiver.
// ----------------------------------------------------------------------------
module bfd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  bfd_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output bfd_pkg::result_t out_res
);

  logic             vld_r;
  bfd_pkg::result_t res_r;

  assign res_ready = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_ready) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule
